// ----- rtl/hst_pkg.sv -----
// shared types, constants and helpers for the history score table
// no dependencies; imported by every module of the block
package hst_pkg;

  localparam int SQUARE_COUNT = 64;
  localparam int COUNTER_BITS = 32;

  localparam int SQ_IN_W  = 6;
  localparam int DEPTH_W  = 7;
  localparam int BONUS_W  = 2 * DEPTH_W;
  localparam int SCORE_W  = 8;

  localparam int SQ_W      = $clog2(SQUARE_COUNT);
  localparam int SQ_EXT_W  = (SQ_W > SQ_IN_W) ? SQ_W : SQ_IN_W;
  localparam int MOD_STEPS = ((1 << SQ_IN_W) - 1) / SQUARE_COUNT;
  localparam int ENTRIES   = SQUARE_COUNT * SQUARE_COUNT;
  localparam int IDX_W     = $clog2(ENTRIES);

  localparam int SCALE = 100;
  localparam int Q_W   = $clog2(SCALE + 1);
  localparam int NUM_W = COUNTER_BITS + Q_W;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               sel;
    logic               best;
    logic [BONUS_W-1:0] bonus;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

  // square index folded into the table range
  function automatic logic [SQ_W-1:0] sq_wrap(input logic [SQ_IN_W-1:0] sq);
    logic [SQ_EXT_W-1:0] r;
    r = SQ_EXT_W'(sq);
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (r >= SQ_EXT_W'(SQUARE_COUNT)) begin
        r = r - SQ_EXT_W'(SQUARE_COUNT);
      end
    end
    return SQ_W'(r);
  endfunction

endpackage

// ----- rtl/hst_front.sv -----
// front end: accepts input items, decodes them into commands and queues them
// depends on hst_pkg
module hst_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_opcode,
  input  logic                        in_table_select,
  input  logic [hst_pkg::SQ_IN_W-1:0] in_from_square,
  input  logic [hst_pkg::SQ_IN_W-1:0] in_to_square,
  input  logic                        in_is_best,
  input  logic [hst_pkg::DEPTH_W-1:0] in_depth,
  input  logic                        clearing,
  output logic                        cmd_valid,
  output hst_pkg::cmd_t               cmd,
  input  logic                        cmd_ready
);
  import hst_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic     accept;
  logic     keep;
  logic     push_q;
  logic     pop_q;
  cmd_t     entry;
  logic [SQ_W-1:0] from_m;
  logic [SQ_W-1:0] to_m;

  assign in_full   = (count_r == CNT_W'(QUEUE_DEPTH)) || clearing;
  assign accept    = in_push && !in_full;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign pop_q     = cmd_valid && cmd_ready;
  assign push_q    = accept && keep;

  // unused opcode is taken and dropped
  always_comb begin
    unique case (op_t'(in_opcode))
      OP_UPDATE, OP_QUERY, OP_CLEAR: keep = 1'b1;
      default:                       keep = 1'b0;
    endcase
  end

  always_comb begin
    from_m      = sq_wrap(in_from_square);
    to_m        = sq_wrap(in_to_square);
    entry.op    = op_t'(in_opcode);
    entry.sel   = in_table_select;
    entry.best  = in_is_best;
    entry.bonus = BONUS_W'(in_depth) * BONUS_W'(in_depth);
    entry.idx   = IDX_W'(from_m) * IDX_W'(SQUARE_COUNT) + IDX_W'(to_m);
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_q) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_q) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_q && !pop_q) begin
        count_r <= count_r + 1'b1;
      end else if (pop_q && !push_q) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/hst_div.sv -----
// iterative scaled divider: floor(SCALE*a/b) for a <= b, one quotient bit per cycle
// depends on hst_pkg
module hst_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [hst_pkg::COUNTER_BITS-1:0] a,
  input  logic [hst_pkg::COUNTER_BITS-1:0] b,
  output logic                             done,
  output logic [hst_pkg::Q_W-1:0]          quot
);
  import hst_pkg::*;

  localparam int STEP_W = $clog2(Q_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsh_r;
  logic [Q_W-1:0]    quot_r;
  logic [NUM_W:0]    diff;
  logic              ge;

  assign diff = {1'b0, rem_r} - {1'b0, dsh_r};
  assign ge   = !diff[NUM_W];
  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        // constant scaling, registered before the first step
        rem_r  <= NUM_W'(a) * NUM_W'(SCALE);
        dsh_r  <= NUM_W'(b) << (Q_W - 1);
        step_r <= STEP_W'(Q_W - 1);
        quot_r <= '0;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= diff[NUM_W-1:0];
        end
        quot_r <= {quot_r[Q_W-2:0], ge};
        dsh_r  <= dsh_r >> 1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/hst_back.sv -----
// back end: history memories, bounds, update, query and clear sequencer, result register
// depends on hst_pkg and hst_div
module hst_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  hst_pkg::cmd_t                      cmd,
  output logic                               cmd_ready,
  output logic                               clearing,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [hst_pkg::SCORE_W-1:0] out_score
);
  import hst_pkg::*;

  localparam int N = COUNTER_BITS;
  localparam logic signed [N:0]   SUM_HI = {2'b00, {(N-1){1'b1}}};
  localparam logic signed [N:0]   SUM_LO = {2'b11, {(N-1){1'b0}}};
  localparam logic signed [N-1:0] CNT_HI = {1'b0, {(N-1){1'b1}}};
  localparam logic signed [N-1:0] CNT_LO = {1'b1, {(N-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_BOUND,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state_r;
  logic [IDX_W-1:0]   clr_addr_r;
  op_t                op_r;
  logic               sel_r;
  logic               best_r;
  logic [BONUS_W-1:0] bonus_r;
  logic [IDX_W-1:0]   idx_r;
  logic signed [N-1:0] new_r;
  logic               neg_r;
  logic [SCORE_W-1:0] res_r;
  logic signed [N-1:0] max_r [2];
  logic signed [N-1:0] min_r [2];
  logic               out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;

  logic signed [N-1:0] q_mem [ENTRIES];
  logic signed [N-1:0] c_mem [ENTRIES];
  logic signed [N-1:0] q_rd_r;
  logic signed [N-1:0] c_rd_r;

  logic               rd_en;
  logic               we_q;
  logic               we_c;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [N-1:0] wr_data;
  logic signed [N-1:0] cur_v;
  logic signed [N:0]   bon_s;
  logic signed [N:0]   sum;
  logic signed [N-1:0] upd_v;
  logic               q_pos;
  logic               q_neg;
  logic [N-1:0]       div_a;
  logic [N-1:0]       div_b;
  logic               div_start;
  logic               div_done;
  logic [Q_W-1:0]     div_quot;
  logic [SCORE_W-1:0] mag;
  logic               out_load;

  assign cmd_ready = (state_r == ST_IDLE);
  assign clearing  = (state_r == ST_CLEAR);
  assign rd_en     = cmd_ready && cmd_valid;
  assign out_empty = !out_valid_r;
  assign out_score = out_score_r;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_pop);
  assign mag       = SCORE_W'(div_quot) + SCORE_W'(1);

  // saturating update and query classification
  always_comb begin
    cur_v = sel_r ? c_rd_r : q_rd_r;
    bon_s = $signed({{(N + 1 - BONUS_W){1'b0}}, bonus_r});
    sum   = best_r ? ({cur_v[N-1], cur_v} + bon_s) : ({cur_v[N-1], cur_v} - bon_s);
    if (sum > SUM_HI) begin
      upd_v = CNT_HI;
    end else if (sum < SUM_LO) begin
      upd_v = CNT_LO;
    end else begin
      upd_v = sum[N-1:0];
    end
    q_pos     = !cur_v[N-1] && (cur_v != '0) && (max_r[sel_r] != '0);
    q_neg     = cur_v[N-1] && (min_r[sel_r] != '0);
    div_a     = q_pos ? cur_v : N'(0) - cur_v;
    div_b     = q_pos ? max_r[sel_r] : N'(0) - min_r[sel_r];
    div_start = (state_r == ST_EXEC) && (op_r == OP_QUERY) && (q_pos || q_neg);
  end

  // memory write steering
  always_comb begin
    we_q    = 1'b0;
    we_c    = 1'b0;
    wr_addr = idx_r;
    wr_data = upd_v;
    if (state_r == ST_CLEAR) begin
      we_q    = 1'b1;
      we_c    = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if ((state_r == ST_EXEC) && (op_r == OP_UPDATE)) begin
      we_q = !sel_r;
      we_c = sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_q) begin
      q_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_rd_r <= q_mem[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      c_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      c_rd_r <= c_mem[cmd.idx];
    end
  end

  hst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      max_r[0]    <= '0;
      max_r[1]    <= '0;
      min_r[0]    <= '0;
      min_r[1]    <= '0;
    end else begin
      // a new result may replace the one popped in the same cycle
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (clr_addr_r == IDX_W'(ENTRIES - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            op_r    <= cmd.op;
            sel_r   <= cmd.sel;
            best_r  <= cmd.best;
            bonus_r <= cmd.bonus;
            idx_r   <= cmd.idx;
            if (cmd.op == OP_CLEAR) begin
              state_r    <= ST_CLEAR;
              clr_addr_r <= '0;
              max_r[0]   <= '0;
              max_r[1]   <= '0;
              min_r[0]   <= '0;
              min_r[1]   <= '0;
            end else begin
              state_r <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (op_r == OP_UPDATE) begin
            new_r   <= upd_v;
            state_r <= ST_BOUND;
          end else if (div_start) begin
            neg_r   <= q_neg;
            state_r <= ST_DIV;
          end else begin
            res_r   <= '0;
            state_r <= ST_OUT;
          end
        end
        ST_BOUND: begin
          if (new_r > max_r[sel_r]) begin
            max_r[sel_r] <= new_r;
          end else if (new_r < min_r[sel_r]) begin
            min_r[sel_r] <= new_r;
          end
          state_r <= ST_IDLE;
        end
        ST_DIV: begin
          if (div_done) begin
            res_r   <= neg_r ? SCORE_W'(0) - mag : mag;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_score_r <= $signed(res_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/history_score_table_unit.sv -----
// history score table: after an item leaves the front queue, an update goes through the
// execute and bound states, a query through execute, the divider (operand load, then the 7
// quotient bits) unless its result is zero, and the output state, and a clear through a memory
// sweep that writes one entry a cycle. the back sequencer finishes one item before it takes the next.
// reset (rst_n low, synchronous) starts the same clearing pass over all ENTRIES; in_full
// stays high until it ends. depends on hst_pkg, hst_front, hst_back
module history_score_table_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel, queue style
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [1:0]                         in_opcode,
  input  logic                               in_table_select,
  input  logic [hst_pkg::SQ_IN_W-1:0]        in_from_square,
  input  logic [hst_pkg::SQ_IN_W-1:0]        in_to_square,
  input  logic                               in_is_best,
  input  logic [hst_pkg::DEPTH_W-1:0]        in_depth,
  input  logic                               in_list_end,
  // result channel, queue style
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [hst_pkg::SCORE_W-1:0] out_score
);
  import hst_pkg::*;

  // command handoff between the decoder and the sequencer
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  // high while a memory sweep runs; holds off new transfers on the input side
  logic clearing;

  // front: decodes opcode, folds squares into a table index, squares the depth,
  // drops the unused opcode and buffers up to two commands.
  // in_list_end only marks list boundaries upstream and changes no state here
  hst_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_table_select (in_table_select),
    .in_from_square  (in_from_square),
    .in_to_square    (in_to_square),
    .in_is_best      (in_is_best),
    .in_depth        (in_depth),
    .clearing        (clearing),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_ready       (cmd_ready)
  );

  // back: one command at a time
  //   update: read entry, saturating add or subtract, write back, then adjust bounds
  //   query:  read entry, pick bound, scaled division, result into output register
  //   clear:  zero bounds and sweep both memories
  // the output register lets the sequencer move on while a result waits for pop
  hst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .clearing  (clearing),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_score (out_score)
  );

endmodule
